/* rtl/core/cleb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_pkg: shared types and constants of the line edit buffer
// Key codes, the command format passed from front to back, queue sizing
// and the status group that the back end reports.
// ----------------------------------------------------------------------------
package cleb_pkg;

   // default line capacity, range 2 to 64
   localparam int LINE_CAPACITY_DEF = 64;

   // widest count a line of up to 64 characters needs
   localparam int CNT_MAX_W = 7;

   // command queue depth, a power of two so the pointers wrap by themselves
   localparam int QUEUE_DEPTH = 4;

   // editing keys
   localparam logic [7:0] KEY_LEFT   = 8'd60;
   localparam logic [7:0] KEY_RIGHT  = 8'd62;
   localparam logic [7:0] KEY_DELETE = 8'd45;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LEFT,
      OP_RIGHT,
      OP_DELETE,
      OP_INSERT
   } op_type;

   // one classified request
   typedef struct packed {
      op_type     op;
      logic [7:0] key;
      logic       eol;
   } cmd_type;

   // write side of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // read side of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // back end status, counts zero-extended to the widest line
   typedef struct packed {
      logic                 busy;
      logic [CNT_MAX_W-1:0] cursor;
      logic [CNT_MAX_W-1:0] length;
   } status_type;

endpackage

/* rtl/core/cleb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_front: request intake and key classification
// Takes requests, turns each key into an editing command and pushes it
// into the command queue. Requests with neither a key nor an end marker
// carry no work and are taken without a queue entry.
// ----------------------------------------------------------------------------
module cleb_front
   import cleb_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_key_code,
   input  logic       req_key_valid,
   input  logic       req_end_of_line,
   input  logic       queue_full,
   output push_type   push
);

   op_type key_op;

   // key decoder
   always_comb begin
      unique case (req_key_code)
         KEY_LEFT:   key_op = OP_LEFT;
         KEY_RIGHT:  key_op = OP_RIGHT;
         KEY_DELETE: key_op = OP_DELETE;
         default:    key_op = OP_INSERT;
      endcase
   end

   // hold off requests while the queue has no room
   assign req_stall = queue_full;

   // queue write
   always_comb begin
      push.valid   = req_valid && !queue_full && (req_key_valid || req_end_of_line);
      push.cmd.op  = req_key_valid ? key_op : OP_NONE;
      push.cmd.key = req_key_code;
      push.cmd.eol = req_end_of_line;
   end

endmodule

/* rtl/core/cleb_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_queue: command queue between front and back end
// A small register fifo that lets the intake keep taking requests while
// the back end shifts the line store or flushes a line.
// ----------------------------------------------------------------------------
module cleb_queue
   import cleb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output head_type head,
   output logic     full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

/* rtl/core/cleb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_back: command execution, line store and response register
// Carries out one command at a time on the line store. Insert and delete
// move the characters behind the cursor one entry per read/write pair;
// an end of line then walks the store into the response register.
// ----------------------------------------------------------------------------
module cleb_back
   import cleb_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_char,
   output logic       rsp_line_empty,
   output logic       rsp_line_overflow,
   output logic       rsp_last_of_line,
   output status_type status
);

   localparam int IDX_W = $clog2(LINE_CAPACITY);
   localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_INS_RD   = 9'b000000010,
      ST_INS_WR   = 9'b000000100,
      ST_INS_PUT  = 9'b000001000,
      ST_DEL_RD   = 9'b000010000,
      ST_DEL_WR   = 9'b000100000,
      ST_FL_RD    = 9'b001000000,
      ST_FL_OUT   = 9'b010000000,
      ST_FL_EMPTY = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] length_ff, length_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] flush_ff, flush_in;

   logic [7:0]       line_store_ff [LINE_CAPACITY];
   logic [7:0]       rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff;
   logic             rsp_empty_ff, rsp_ovf_ff, rsp_last_ff;
   logic             out_free, load;
   logic [7:0]       load_char;
   logic             load_empty, load_last;

   logic             op_done, op_eol, clear;
   logic [CNT_W-1:0] ptr_dec, ptr_inc, cursor_inc, cursor_dec;
   logic [CNT_W-1:0] length_inc, length_dec, flush_inc;

   assign ptr_dec    = ptr_ff - ONE;
   assign ptr_inc    = ptr_ff + ONE;
   assign cursor_inc = cursor_ff + ONE;
   assign cursor_dec = cursor_ff - ONE;
   assign length_inc = length_ff + ONE;
   assign length_dec = length_ff - ONE;
   assign flush_inc  = flush_ff + ONE;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // command sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cursor_in   = cursor_ff;
      length_in   = length_ff;
      overflow_in = overflow_ff;
      ptr_in      = ptr_ff;
      flush_in    = flush_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cursor_ff[IDX_W-1:0];
      wr_data     = cmd_ff.key;
      rd_en       = 1'b0;
      rd_addr     = flush_ff[IDX_W-1:0];
      load        = 1'b0;
      load_char   = rd_data_ff;
      load_empty  = 1'b0;
      load_last   = 1'b0;
      op_done     = 1'b0;
      op_eol      = cmd_ff.eol;
      clear       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            op_eol = head.cmd.eol;
            if (head.valid) begin
               pop     = 1'b1;
               cmd_in  = head.cmd;
               op_done = 1'b1;
               case (head.cmd.op)
                  OP_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_dec;
                     end
                  end
                  OP_RIGHT: begin
                     if (cursor_ff != length_ff) begin
                        cursor_in = cursor_inc;
                     end
                  end
                  OP_DELETE: begin
                     if (cursor_ff == '0) begin
                        // delete at the start of the line does nothing
                     end else if (cursor_ff == length_ff) begin
                        cursor_in = cursor_dec;
                        length_in = length_dec;
                     end else begin
                        ptr_in   = cursor_ff;
                        state_in = ST_DEL_RD;
                        op_done  = 1'b0;
                     end
                  end
                  OP_INSERT: begin
                     if (length_ff == CAP) begin
                        overflow_in = 1'b1;
                     end else if (cursor_ff == length_ff) begin
                        wr_en     = 1'b1;
                        wr_data   = head.cmd.key;
                        cursor_in = cursor_inc;
                        length_in = length_inc;
                     end else begin
                        ptr_in   = length_ff;
                        state_in = ST_INS_RD;
                        op_done  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // open a hole at the cursor, last character first
         ST_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_dec[IDX_W-1:0];
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            if (ptr_dec == cursor_ff) begin
               state_in = ST_INS_PUT;
            end else begin
               ptr_in   = ptr_dec;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_PUT: begin
            wr_en     = 1'b1;
            cursor_in = cursor_inc;
            length_in = length_inc;
            op_done   = 1'b1;
         end
         // close the gap before the cursor, first character first
         ST_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff[IDX_W-1:0];
            state_in = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_dec[IDX_W-1:0];
            wr_data = rd_data_ff;
            if (ptr_inc == length_ff) begin
               cursor_in = cursor_dec;
               length_in = length_dec;
               op_done   = 1'b1;
            end else begin
               ptr_in   = ptr_inc;
               state_in = ST_DEL_RD;
            end
         end
         // line flush
         ST_FL_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FL_OUT;
         end
         ST_FL_OUT: begin
            if (out_free) begin
               load      = 1'b1;
               load_last = (flush_inc == length_ff);
               if (flush_inc == length_ff) begin
                  clear    = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  flush_in = flush_inc;
                  state_in = ST_FL_RD;
               end
            end
         end
         ST_FL_EMPTY: begin
            if (out_free) begin
               load       = 1'b1;
               load_char  = 8'd0;
               load_empty = 1'b1;
               load_last  = 1'b1;
               clear      = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // after the edit, either wait for the next command or start a flush
      if (op_done) begin
         flush_in = '0;
         if (!op_eol) begin
            state_in = ST_IDLE;
         end else if (length_in == '0) begin
            state_in = ST_FL_EMPTY;
         end else begin
            state_in = ST_FL_RD;
         end
      end

      if (clear) begin
         cursor_in   = '0;
         length_in   = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cursor_ff   <= '0;
         length_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cursor_ff   <= cursor_in;
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      ptr_ff   <= ptr_in;
      flush_ff <= flush_in;
   end

   // line store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_store_ff[rd_addr];
      end
   end

   // response register
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff  <= load_char;
         rsp_empty_ff <= load_empty;
         rsp_ovf_ff   <= overflow_ff;
         rsp_last_ff  <= load_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_text_char     = rsp_char_ff;
   assign rsp_line_empty    = rsp_empty_ff;
   assign rsp_line_overflow = rsp_ovf_ff;
   assign rsp_last_of_line  = rsp_last_ff;

   assign status.busy   = (state_ff != ST_IDLE);
   assign status.cursor = CNT_MAX_W'(cursor_ff);
   assign status.length = CNT_MAX_W'(length_ff);

endmodule

/* rtl/core/cursor_line_edit_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_unit: line editor with a cursor
// Keeps one line of text and edits it from a stream of key codes.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one key a request (key code, key valid, end of line).
//   '<' and '>' move the cursor, '-' deletes before it, any other code is
//   inserted at it; a key into a full line is dropped and marks overflow.
//   rsp_ channel: on end of line, one response a character in order, the
//   last one flagged; an empty line gives one response marked empty.
// Execution
//   Requests go into a four-entry command queue and are taken whenever it
//   has room. Cursor moves, deletes at the end of the line and appends are
//   done in the idle state as the back end takes the command. An insert or
//   delete inside the line does one store read and one store write for
//   each character behind the cursor. A flush reads each character from
//   the store and then loads it into the response register; an empty line
//   loads its one response, marked empty, straight away.
// Reset and stalls
//   Reset empties the queue and the line and clears the overflow mark; the
//   store contents are left as they are. A stalled response holds in its
//   register and the flush waits; requests keep queueing until it fills.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_unit
   import cleb_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_key_code,
   input  logic       req_key_valid,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_char,
   output logic       rsp_line_empty,
   output logic       rsp_line_overflow,
   output logic       rsp_last_of_line
);

   push_type   push;
   head_type   head;
   logic       queue_full;
   logic       queue_pop;
   status_type status;

   // request intake
   cleb_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_code    (req_key_code),
      .req_key_valid   (req_key_valid),
      .req_end_of_line (req_end_of_line),
      .queue_full      (queue_full),
      .push            (push)
   );

   // command queue
   cleb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (queue_pop),
      .head  (head),
      .full  (queue_full)
   );

   // editing and flush
   cleb_back #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_text_char     (rsp_text_char),
      .rsp_line_empty    (rsp_line_empty),
      .rsp_line_overflow (rsp_line_overflow),
      .rsp_last_of_line  (rsp_last_of_line),
      .status            (status)
   );

   // cursor never runs past the end of the line
   assert property (@(posedge clock) disable iff (reset)
      status.cursor <= status.length)
      else $error("cursor beyond line length");

   // line never grows past capacity
   assert property (@(posedge clock) disable iff (reset)
      status.length <= CNT_MAX_W'(LINE_CAPACITY))
      else $error("line length beyond capacity");

   // back end only takes commands that the queue holds, and only when idle
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (head.valid && !status.busy))
      else $error("command taken from empty queue or while busy");

   // a request taken with work in it leaves a command in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_key_valid || req_end_of_line) && !queue_pop)
      |=> head.valid)
      else $error("accepted request lost before the back end");

endmodule
